// ----- src/iprst_pkg.sv -----
// package: prime table and sizes for the interval prime residue survivor test
package iprst_pkg;

  localparam int PRIME_SLOTS = 309;
  localparam int IDX_W = $clog2(PRIME_SLOTS);
  localparam int CAND_W = 64;
  localparam int CNT_W = $clog2(CAND_W);
  localparam int K_W = 10;
  localparam int P_W = 11;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PRIME_SLOTS - 1);

  localparam logic [P_W-1:0] PRIME_ROM [PRIME_SLOTS] = '{
    11'd2, 11'd3, 11'd5, 11'd7, 11'd11, 11'd13, 11'd17, 11'd19, 11'd23, 11'd29,
    11'd31, 11'd37, 11'd41, 11'd43, 11'd47, 11'd53, 11'd59, 11'd61, 11'd67, 11'd71,
    11'd73, 11'd79, 11'd83, 11'd89, 11'd97,
    11'd101, 11'd103, 11'd107, 11'd109, 11'd113, 11'd127, 11'd131, 11'd137, 11'd139,
    11'd149, 11'd151, 11'd157, 11'd163, 11'd167, 11'd173, 11'd179, 11'd181, 11'd191,
    11'd193, 11'd197, 11'd199,
    11'd211, 11'd223, 11'd227, 11'd229, 11'd233, 11'd239, 11'd241, 11'd251, 11'd257,
    11'd263, 11'd269, 11'd271, 11'd277, 11'd281, 11'd283, 11'd293,
    11'd307, 11'd311, 11'd313, 11'd317, 11'd331, 11'd337, 11'd347, 11'd349, 11'd353,
    11'd359, 11'd367, 11'd373, 11'd379, 11'd383, 11'd389, 11'd397,
    11'd401, 11'd409, 11'd419, 11'd421, 11'd431, 11'd433, 11'd439, 11'd443, 11'd449,
    11'd457, 11'd461, 11'd463, 11'd467, 11'd479, 11'd487, 11'd491, 11'd499,
    11'd503, 11'd509, 11'd521, 11'd523, 11'd541, 11'd547, 11'd557, 11'd563, 11'd569,
    11'd571, 11'd577, 11'd587, 11'd593, 11'd599,
    11'd601, 11'd607, 11'd613, 11'd617, 11'd619, 11'd631, 11'd641, 11'd643, 11'd647,
    11'd653, 11'd659, 11'd661, 11'd673, 11'd677, 11'd683, 11'd691,
    11'd701, 11'd709, 11'd719, 11'd727, 11'd733, 11'd739, 11'd743, 11'd751, 11'd757,
    11'd761, 11'd769, 11'd773, 11'd787, 11'd797,
    11'd809, 11'd811, 11'd821, 11'd823, 11'd827, 11'd829, 11'd839, 11'd853, 11'd857,
    11'd859, 11'd863, 11'd877, 11'd881, 11'd883, 11'd887,
    11'd907, 11'd911, 11'd919, 11'd929, 11'd937, 11'd941, 11'd947, 11'd953, 11'd967,
    11'd971, 11'd977, 11'd983, 11'd991, 11'd997,
    11'd1009, 11'd1013, 11'd1019, 11'd1021, 11'd1031, 11'd1033, 11'd1039, 11'd1049,
    11'd1051, 11'd1061, 11'd1063, 11'd1069, 11'd1087, 11'd1091, 11'd1093, 11'd1097,
    11'd1103, 11'd1109, 11'd1117, 11'd1123, 11'd1129, 11'd1151, 11'd1153, 11'd1163,
    11'd1171, 11'd1181, 11'd1187, 11'd1193,
    11'd1201, 11'd1213, 11'd1217, 11'd1223, 11'd1229, 11'd1231, 11'd1237, 11'd1249,
    11'd1259, 11'd1277, 11'd1279, 11'd1283, 11'd1289, 11'd1291, 11'd1297,
    11'd1301, 11'd1303, 11'd1307, 11'd1319, 11'd1321, 11'd1327, 11'd1361, 11'd1367,
    11'd1373, 11'd1381, 11'd1399,
    11'd1409, 11'd1423, 11'd1427, 11'd1429, 11'd1433, 11'd1439, 11'd1447, 11'd1451,
    11'd1453, 11'd1459, 11'd1471, 11'd1481, 11'd1483, 11'd1487, 11'd1489, 11'd1493,
    11'd1499,
    11'd1511, 11'd1523, 11'd1531, 11'd1543, 11'd1549, 11'd1553, 11'd1559, 11'd1567,
    11'd1571, 11'd1579, 11'd1583, 11'd1597,
    11'd1601, 11'd1607, 11'd1609, 11'd1613, 11'd1619, 11'd1621, 11'd1627, 11'd1637,
    11'd1657, 11'd1663, 11'd1667, 11'd1669, 11'd1693, 11'd1697, 11'd1699,
    11'd1709, 11'd1721, 11'd1723, 11'd1733, 11'd1741, 11'd1747, 11'd1753, 11'd1759,
    11'd1777, 11'd1783, 11'd1787, 11'd1789,
    11'd1801, 11'd1811, 11'd1823, 11'd1831, 11'd1847, 11'd1861, 11'd1867, 11'd1871,
    11'd1873, 11'd1877, 11'd1879, 11'd1889,
    11'd1901, 11'd1907, 11'd1913, 11'd1931, 11'd1933, 11'd1949, 11'd1951, 11'd1973,
    11'd1979, 11'd1987, 11'd1993, 11'd1997, 11'd1999,
    11'd2003, 11'd2011, 11'd2017, 11'd2027, 11'd2029, 11'd2039
  };

endpackage

// ----- src/interval_prime_residue_survivor_test_unit.sv -----
// top level: interval prime residue survivor test with a shared bit-serial modulo unit
// per table prime: fetch and check; primes at or below k are skipped, a prime in (k, 2k) runs
// one 64-step restoring modulo and a residue test, a prime at or above 2k ends the walk, then present
// one item at a time; the next is taken only after the last result enters the output register
// a finished result waits in the output register while the next item is accepted
// reset: synchronous, active high; clears control state and sets k_reg to 1
module interval_prime_residue_survivor_test_unit
  import iprst_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [K_W-1:0]    window_k,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CAND_W-1:0] candidate,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              survivor,
  output logic [P_W-1:0]    blocking_prime,
  output logic [K_W-1:0]    blocking_residue
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_TEST  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]        state;
  logic [K_W-1:0]    k_reg;
  logic [IDX_W-1:0]  idx;
  logic [P_W-1:0]    prime_q;
  logic [CAND_W-1:0] cand_sh;
  logic [P_W-1:0]    rem;
  logic [CNT_W-1:0]  cnt;
  logic              res_surv;
  logic [P_W-1:0]    res_prime;
  logic [K_W-1:0]    res_residue;

  logic [P_W-1:0]    upper;
  logic [P_W:0]      trial;
  logic [P_W:0]      diff;
  logic [P_W-1:0]    rem_next;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign upper     = {k_reg, 1'b0};

  // shared restoring modulo step
  assign trial    = {rem, cand_sh[CAND_W-1]};
  assign diff     = trial - {1'b0, prime_q};
  assign rem_next = diff[P_W] ? trial[P_W-1:0] : diff[P_W-1:0];

  // prime table read, registered
  always_ff @(posedge clk) begin
    prime_q <= PRIME_ROM[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k_reg <= K_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      k_reg <= window_k;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      idx       <= '0;
      cnt       <= '0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cand_sh <= candidate;
            idx     <= '0;
            state   <= S_FETCH;
          end
        end
        S_FETCH: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (prime_q <= {1'b0, k_reg}) begin
            if (idx == LAST_IDX) begin
              res_surv    <= 1'b1;
              res_prime   <= '0;
              res_residue <= '0;
              state       <= S_DONE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_FETCH;
            end
          end else if (prime_q >= upper) begin
            res_surv    <= 1'b1;
            res_prime   <= '0;
            res_residue <= '0;
            state       <= S_DONE;
          end else begin
            rem   <= '0;
            cnt   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem     <= rem_next;
          cand_sh <= {cand_sh[CAND_W-2:0], cand_sh[CAND_W-1]};
          cnt     <= cnt + 1'b1;
          if (cnt == CNT_W'(CAND_W - 1)) begin
            state <= S_TEST;
          end
        end
        S_TEST: begin
          if (rem != '0 && rem <= {1'b0, k_reg}) begin
            res_surv    <= 1'b0;
            res_prime   <= prime_q;
            res_residue <= rem[K_W-1:0];
            state       <= S_DONE;
          end else if (idx == LAST_IDX) begin
            res_surv    <= 1'b1;
            res_prime   <= '0;
            res_residue <= '0;
            state       <= S_DONE;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_FETCH;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid        <= 1'b1;
            survivor         <= res_surv;
            blocking_prime   <= res_prime;
            blocking_residue <= res_residue;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- tb/sv/interval_prime_residue_survivor_test_unit_tb.sv -----
// testbench: interval prime residue survivor test unit against its own residue predictor
module interval_prime_residue_survivor_test_unit_tb
  import iprst_pkg::*;
();

  localparam int SIEVE_LIMIT = 2048;
  localparam logic [CAND_W-1:0] ALL_ONES = '1;

  typedef struct packed {
    logic [CAND_W-1:0] cand;
    logic [K_W-1:0]    k;
    logic              surv;
    logic [P_W-1:0]    prime;
    logic [K_W-1:0]    residue;
  } verdict_t;

  class survivor_oracle;
    int unsigned primes[$];
    int unsigned window;
    verdict_t    expected_verdicts[$];
    int          failures;
    int          results_seen;

    function new();
      bit mark [SIEVE_LIMIT];
      for (int v = 2; v < SIEVE_LIMIT; v++) begin
        if (!mark[v]) begin
          if (primes.size() < PRIME_SLOTS) primes.insert(primes.size(), v);
          for (int m = v * v; m < SIEVE_LIMIT; m += v) mark[m] = 1'b1;
        end
      end
      window = 1;
    endfunction

    function void set_window(logic [K_W-1:0] k);
      window = k;
    endfunction

    function verdict_t predict_verdict(logic [CAND_W-1:0] n);
      verdict_t    v;
      logic [63:0] r;
      v.cand = n;
      v.k = K_W'(window);
      v.surv = 1'b1;
      v.prime = '0;
      v.residue = '0;
      for (int i = 0; i < primes.size(); i++) begin
        if (primes[i] <= window) continue;
        if (primes[i] >= 2 * window) break;
        r = n % 64'(primes[i]);
        if (r >= 1 && r <= window) begin
          v.surv = 1'b0;
          v.prime = P_W'(primes[i]);
          v.residue = K_W'(r);
          break;
        end
      end
      return v;
    endfunction

    function void note_candidate(logic [CAND_W-1:0] n);
      expected_verdicts.insert(expected_verdicts.size(), predict_verdict(n));
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    function void check_verdict(logic s, logic [P_W-1:0] p, logic [K_W-1:0] r);
      verdict_t e;
      results_seen++;
      if (expected_verdicts.size() == 0) begin
        report($sformatf("unexpected result: survivor %0b prime %0d residue %0d", s, p, r));
        return;
      end
      e = expected_verdicts.pop_front();
      if (e.surv !== s || e.prime !== p || e.residue !== r)
        report($sformatf({"mismatch: candidate %h k %0d expected survivor %0b prime %0d ",
                          "residue %0d, got survivor %0b prime %0d residue %0d"},
                         e.cand, e.k, e.surv, e.prime, e.residue, s, p, r));
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [K_W-1:0]    window_k = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CAND_W-1:0] candidate = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              survivor;
  logic [P_W-1:0]    blocking_prime;
  logic [K_W-1:0]    blocking_residue;

  logic hold_rx = 1'b0;
  int   tx_idle_pct = 0;
  int   rx_stall_pct = 0;
  int   sent_count = 0;

  survivor_oracle oracle = new();

  interval_prime_residue_survivor_test_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .window_k(window_k),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .candidate(candidate),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .survivor(survivor),
    .blocking_prime(blocking_prime),
    .blocking_residue(blocking_residue)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) oracle.set_window(window_k);
      if (in_valid && in_ready) oracle.note_candidate(candidate);
      if (out_valid && out_ready) oracle.check_verdict(survivor, blocking_prime, blocking_residue);
    end
    out_ready <= !hold_rx && ($urandom_range(99) >= rx_stall_pct);
  end

  task automatic send_candidate(input logic [CAND_W-1:0] n);
    candidate <= n;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sent_count++;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  task automatic write_window(input logic [K_W-1:0] k);
    in_valid <= 1'b0;
    while (oracle.results_seen < sent_count) @(posedge clk);
    cfg_valid <= 1'b1;
    window_k <= k;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // mix of raw, small, interval-product based and bit-pattern candidates
  function automatic logic [CAND_W-1:0] pick_candidate(int unsigned k);
    logic [CAND_W-1:0] prod;
    logic [CAND_W-1:0] span;
    logic [CAND_W-1:0] n;
    int unsigned       pmin;
    int unsigned       r;
    int unsigned       sh;
    int                sel;
    sel = $urandom_range(99);
    sh = $urandom_range(63);
    if (sel < 35) return {$urandom, $urandom};
    if (sel < 55) return 64'($urandom_range(2 * k + 2, 0));
    if (sel < 85) begin
      prod = 1;
      pmin = 0;
      foreach (oracle.primes[i]) begin
        if (oracle.primes[i] > k && oracle.primes[i] < 2 * k) begin
          if (pmin == 0) pmin = oracle.primes[i];
          if (prod <= ALL_ONES / 64'(oracle.primes[i])) prod = prod * 64'(oracle.primes[i]);
        end
      end
      span = ALL_ONES / prod;
      n = ({$urandom, $urandom} % span) * prod;
      r = 0;
      if (pmin > k + 1 && $urandom_range(1) == 1) r = $urandom_range(pmin - 1, k + 1);
      return n + 64'(r);
    end
    case ($urandom_range(2))
      0: return ALL_ONES >> sh;
      1: return 64'(1) << sh;
      default: return ~(64'(1) << sh);
    endcase
  endfunction

  initial begin
    int unsigned k;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // window after reset
    send_candidate(64'd0);
    send_candidate(ALL_ONES);
    send_candidate(64'd1);
    send_candidate(64'd2);

    // empty interval
    write_window(10'd0);
    send_candidate(64'h5555_5555_5555_5555);
    send_candidate(ALL_ONES);

    write_window(10'd2);
    for (int v = 0; v < 7; v++) send_candidate(64'(v));

    // widest window, full walks for survivors
    write_window(10'd1023);
    send_candidate(64'd0);
    send_candidate(64'd1023);
    send_candidate(64'd1030);
    send_candidate(ALL_ONES);
    send_candidate(64'h8000_0000_0000_0000);
    send_candidate(64'd1);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin k = $urandom_range(12, 2); tx_idle_pct = 0; rx_stall_pct = 0; end
        1: begin k = $urandom_range(60, 13); tx_idle_pct = 78; rx_stall_pct = 0; end
        2: begin k = $urandom_range(400, 61); tx_idle_pct = 0; rx_stall_pct = 78; end
        3: begin k = $urandom_range(1022, 401); tx_idle_pct = 15; rx_stall_pct = 15; end
        4: begin k = $urandom_range(30, 3); tx_idle_pct = 0; rx_stall_pct = 0; end
        default: begin k = 1023; tx_idle_pct = 15; rx_stall_pct = 15; end
      endcase
      write_window(K_W'(k));
      // long receiver hold-off so the block backs up into its input
      if (ph == 4) begin
        fork
          begin
            hold_rx <= 1'b1;
            repeat (2500) @(posedge clk);
            hold_rx <= 1'b0;
          end
        join_none
      end
      for (int i = 0; i < 14; i++) send_candidate(pick_candidate(k));
    end

    in_valid <= 1'b0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    while (oracle.results_seen < sent_count) @(posedge clk);
    repeat (100) @(posedge clk);
    if (oracle.expected_verdicts.size() != 0)
      oracle.report($sformatf("missing results: %0d", oracle.expected_verdicts.size()));
    if (oracle.failures == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #(12 * 5_000_000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
